// ===== src/kdz_pkg.sv =====
// Shared types, widths and codes for the kinship degree z score core.
`default_nettype none
package kdz_pkg;

    localparam int WINDOW_COUNT_BITS = 16;

    localparam int RATE_W  = 24;
    localparam int SOS_W   = 56;
    localparam int Z_W     = 32;
    localparam int NUM_W   = 64;
    localparam int M2_W    = 2 * RATE_W;
    localparam int PART_W  = WINDOW_COUNT_BITS + RATE_W;
    localparam int SUM_W   = WINDOW_COUNT_BITS + M2_W + 1;
    localparam int DEN_W   = 2 * WINDOW_COUNT_BITS;
    localparam int ROOT_W  = NUM_W / 2;
    localparam int SQR_REM_W = ROOT_W + 2;
    localparam int MDIV_W  = ROOT_W + 6;
    localparam int DIV_D_W = (DEN_W > MDIV_W) ? DEN_W : MDIV_W;
    localparam int PROD_W  = 2 * RATE_W;
    localparam int MAG_STEPS = PROD_W;
    localparam int CFG_AW  = 4;

    localparam logic [1:0] DEG_IDENTICAL = 2'd0;
    localparam logic [1:0] DEG_FIRST     = 2'd1;
    localparam logic [1:0] DEG_SECOND    = 2'd2;
    localparam logic [1:0] DEG_UNRELATED = 2'd3;

    localparam logic [CFG_AW-1:0] ADDR_CUT_IDENTICAL = 4'h0;
    localparam logic [CFG_AW-1:0] ADDR_CUT_FIRST     = 4'h4;
    localparam logic [CFG_AW-1:0] ADDR_CUT_SECOND    = 4'h8;

    typedef struct packed {
        logic [1:0]        deg;
        logic              ok;
        logic              neg;
        logic [RATE_W-1:0] ad;
        logic [RATE_W-1:0] bg;
    } side_t;

    typedef struct packed {
        logic               vld;
        logic [DIV_D_W-1:0] rem;
        logic [NUM_W-1:0]   work;
        logic [DIV_D_W-1:0] dvs;
        side_t              side;
    } div_bus_t;

    typedef struct packed {
        logic                 vld;
        logic [SQR_REM_W-1:0] rem;
        logic [ROOT_W-1:0]    root;
        logic [NUM_W-1:0]     rad;
        side_t                side;
    } sqrt_bus_t;

endpackage
`default_nettype wire

// ===== src/kdz_div_cell.sv =====
// One restoring division cell: retires one quotient bit per cycle.
`default_nettype none
module kdz_div_cell (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire kdz_pkg::div_bus_t in_bus,
    output kdz_pkg::div_bus_t      out_bus
);

    logic                       vld_reg;
    kdz_pkg::div_bus_t          data_reg;
    kdz_pkg::div_bus_t          data_next;
    logic [kdz_pkg::DIV_D_W:0]  rem_sh;
    logic [kdz_pkg::DIV_D_W:0]  rem_sub;
    logic                       ge;

    always_comb
    begin
        rem_sh  = {in_bus.rem, in_bus.work[kdz_pkg::NUM_W-1]};
        rem_sub = rem_sh - {1'b0, in_bus.dvs};
        ge      = (rem_sh >= {1'b0, in_bus.dvs});
        data_next      = in_bus;
        data_next.rem  = ge ? rem_sub[kdz_pkg::DIV_D_W-1:0] : rem_sh[kdz_pkg::DIV_D_W-1:0];
        data_next.work = {in_bus.work[kdz_pkg::NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_bus.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        out_bus     = data_reg;
        out_bus.vld = vld_reg;
    end

endmodule
`default_nettype wire

// ===== src/kdz_sqrt_cell.sv =====
// One square root cell: retires one root bit per cycle from two radicand bits.
`default_nettype none
module kdz_sqrt_cell (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire kdz_pkg::sqrt_bus_t in_bus,
    output kdz_pkg::sqrt_bus_t      out_bus
);

    logic                          vld_reg;
    kdz_pkg::sqrt_bus_t            data_reg;
    kdz_pkg::sqrt_bus_t            data_next;
    logic [kdz_pkg::SQR_REM_W+1:0] rem_sh;
    logic [kdz_pkg::SQR_REM_W+1:0] trial;
    logic [kdz_pkg::SQR_REM_W+1:0] rem_sub;
    logic                          ge;

    always_comb
    begin
        rem_sh  = {in_bus.rem, in_bus.rad[kdz_pkg::NUM_W-1 -: 2]};
        trial   = {2'b00, in_bus.root, 2'b01};
        rem_sub = rem_sh - trial;
        ge      = (rem_sh >= trial);
        data_next      = in_bus;
        data_next.rem  = ge ? rem_sub[kdz_pkg::SQR_REM_W-1:0]
                            : rem_sh[kdz_pkg::SQR_REM_W-1:0];
        data_next.root = {in_bus.root[kdz_pkg::ROOT_W-2:0], ge};
        data_next.rad  = {in_bus.rad[kdz_pkg::NUM_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_bus.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        out_bus     = data_reg;
        out_bus.vld = vld_reg;
    end

endmodule
`default_nettype wire

// ===== src/kinship_degree_z_score_core.sv =====
// Top level of the kinship degree z score core: front stages, cell chains and output.
//
// The core accepts one pair on every clock cycle (busy is held low) and gives its
// result marked by done for one cycle; the receiver cannot stall.
// The path runs through four front stages (input register, square and degree, products,
// variance), a 64-cell variance divider, a 32-cell square root, one scaling stage,
// a 48-cell z divider and the output register. The cut registers may be written at
// any time the core is idle.
`default_nettype none
module kinship_degree_z_score_core (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire  [23:0]                           mean_rate,
    input  wire                                   mean_valid,
    input  wire  [23:0]                           norm_rate,
    input  wire                                   norm_valid,
    input  wire  [23:0]                           background_rate,
    input  wire  [kdz_pkg::WINDOW_COUNT_BITS-1:0] window_count,
    input  wire  [55:0]                           sum_of_squares,
    output logic                                  done,
    output logic [1:0]                            degree_code,
    output logic signed [31:0]                    z_score,
    output logic                                  z_valid,
    output logic                                  z_saturated,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [kdz_pkg::CFG_AW-1:0]            paddr,
    input  wire  [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int WB = kdz_pkg::WINDOW_COUNT_BITS;
    localparam int RW = kdz_pkg::RATE_W;

    // Configuration registers.
    logic [RW-1:0] cut_identical_reg;
    logic [RW-1:0] cut_first_reg;
    logic [RW-1:0] cut_second_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_identical_reg <= 24'd2621440;
            cut_first_reg     <= 24'd3407872;
            cut_second_reg    <= 24'd3801088;
        end
        else if (cfg_wr)
        begin
            if (paddr == kdz_pkg::ADDR_CUT_IDENTICAL)
            begin
                cut_identical_reg <= pwdata[RW-1:0];
            end
            if (paddr == kdz_pkg::ADDR_CUT_FIRST)
            begin
                cut_first_reg <= pwdata[RW-1:0];
            end
            if (paddr == kdz_pkg::ADDR_CUT_SECOND)
            begin
                cut_second_reg <= pwdata[RW-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == kdz_pkg::ADDR_CUT_IDENTICAL)
        begin
            prdata = {8'd0, cut_identical_reg};
        end
        else if (paddr == kdz_pkg::ADDR_CUT_FIRST)
        begin
            prdata = {8'd0, cut_first_reg};
        end
        else if (paddr == kdz_pkg::ADDR_CUT_SECOND)
        begin
            prdata = {8'd0, cut_second_reg};
        end
    end

    // Stage 0: input register.
    logic          s0_vld_reg;
    logic [RW-1:0] s0_m_reg;
    logic          s0_mv_reg;
    logic [RW-1:0] s0_r_reg;
    logic          s0_rv_reg;
    logic [RW-1:0] s0_b_reg;
    logic [WB-1:0] s0_n_reg;
    logic [55:0]   s0_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_m_reg  <= mean_rate;
        s0_mv_reg <= mean_valid;
        s0_r_reg  <= norm_rate;
        s0_rv_reg <= norm_valid;
        s0_b_reg  <= background_rate;
        s0_n_reg  <= window_count;
        s0_s_reg  <= sum_of_squares;
    end

    // Stage 1: degree class, mean squared and the n*(n-1) divisor.
    logic [1:0]            s1_deg;
    logic [RW-1:0]         s1_bound;
    logic                  s1_ok;
    logic                  s1_vld_reg;
    kdz_pkg::side_t        s1_side_reg;
    kdz_pkg::side_t        s1_side_next;
    logic [kdz_pkg::M2_W-1:0]  s1_m2_reg;
    logic [kdz_pkg::DEN_W-1:0] s1_den_reg;
    logic [WB-1:0]         s1_n_reg;
    logic [55:0]           s1_s_reg;

    always_comb
    begin
        priority if (!s0_rv_reg)                 s1_deg = kdz_pkg::DEG_UNRELATED;
        else if (s0_r_reg < cut_identical_reg)   s1_deg = kdz_pkg::DEG_IDENTICAL;
        else if (s0_r_reg < cut_first_reg)       s1_deg = kdz_pkg::DEG_FIRST;
        else if (s0_r_reg < cut_second_reg)      s1_deg = kdz_pkg::DEG_SECOND;
        else                                     s1_deg = kdz_pkg::DEG_UNRELATED;

        if (s1_deg == kdz_pkg::DEG_IDENTICAL)
        begin
            s1_bound = cut_identical_reg;
        end
        else if (s1_deg == kdz_pkg::DEG_FIRST)
        begin
            s1_bound = cut_first_reg;
        end
        else
        begin
            s1_bound = cut_second_reg;
        end

        s1_ok = (s0_n_reg >= WB'(2)) && (s0_b_reg != '0) && s0_mv_reg && s0_rv_reg;

        s1_side_next.deg = s1_deg;
        s1_side_next.ok  = s1_ok;
        s1_side_next.neg = (s1_bound < s0_r_reg);
        s1_side_next.ad  = (s1_bound < s0_r_reg) ? (s0_r_reg - s1_bound)
                                                  : (s1_bound - s0_r_reg);
        s1_side_next.bg  = s0_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg <= s1_side_next;
        s1_m2_reg   <= s0_m_reg * s0_m_reg;
        s1_den_reg  <= s0_n_reg * (s0_n_reg - WB'(1));
        s1_n_reg    <= s0_n_reg;
        s1_s_reg    <= s0_s_reg;
    end

    // Stage 2: n times the two halves of the mean square.
    logic                       s2_vld_reg;
    kdz_pkg::side_t             s2_side_reg;
    logic [kdz_pkg::PART_W-1:0] s2_p1_reg;
    logic [kdz_pkg::PART_W-1:0] s2_p2_reg;
    logic [kdz_pkg::DEN_W-1:0]  s2_den_reg;
    logic [55:0]                s2_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s1_side_reg;
        s2_p1_reg   <= s1_n_reg * s1_m2_reg[RW-1:0];
        s2_p2_reg   <= s1_n_reg * s1_m2_reg[kdz_pkg::M2_W-1:RW];
        s2_den_reg  <= s1_den_reg;
        s2_s_reg    <= s1_s_reg;
    end

    // Stage 3: variance numerator, clamped at zero by forcing it to zero.
    logic [kdz_pkg::SUM_W-1:0] s3_sum;
    logic [kdz_pkg::SUM_W-1:0] s3_t;
    logic [kdz_pkg::NUM_W-1:0] s3_num;
    logic [kdz_pkg::NUM_W-1:0] s3_diff;
    kdz_pkg::div_bus_t         s3_bus_reg;
    kdz_pkg::div_bus_t         s3_bus_next;
    logic                      s3_vld_reg;

    always_comb
    begin
        s3_sum  = {1'b0, s2_p2_reg, {RW{1'b0}}} + kdz_pkg::SUM_W'(s2_p1_reg);
        s3_t    = kdz_pkg::SUM_W'({s2_s_reg, 8'd0});
        s3_diff = s3_t[kdz_pkg::NUM_W-1:0] - s3_sum[kdz_pkg::NUM_W-1:0];
        s3_num  = (s3_sum >= s3_t) ? '0 : s3_diff;

        s3_bus_next.vld  = 1'b1;
        s3_bus_next.rem  = '0;
        s3_bus_next.work = s3_num;
        s3_bus_next.dvs  = kdz_pkg::DIV_D_W'(s2_den_reg);
        s3_bus_next.side = s2_side_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_bus_reg <= s3_bus_next;
    end

    // Variance divider chain.
    kdz_pkg::div_bus_t var_bus [kdz_pkg::NUM_W+1];

    always_comb
    begin
        var_bus[0]     = s3_bus_reg;
        var_bus[0].vld = s3_vld_reg;
    end

    for (genvar gi = 0; gi < kdz_pkg::NUM_W; gi++)
    begin : g_var_div
        kdz_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_bus  (var_bus[gi]),
            .out_bus (var_bus[gi+1])
        );
    end

    // Square root chain.
    kdz_pkg::sqrt_bus_t sq_bus [kdz_pkg::ROOT_W+1];

    always_comb
    begin
        sq_bus[0].vld  = var_bus[kdz_pkg::NUM_W].vld;
        sq_bus[0].rem  = '0;
        sq_bus[0].root = '0;
        sq_bus[0].rad  = var_bus[kdz_pkg::NUM_W].work;
        sq_bus[0].side = var_bus[kdz_pkg::NUM_W].side;
    end

    for (genvar gj = 0; gj < kdz_pkg::ROOT_W; gj++)
    begin : g_sqrt
        kdz_sqrt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_bus  (sq_bus[gj]),
            .out_bus (sq_bus[gj+1])
        );
    end

    // Scaling stage: distance times background over the error times 64.
    kdz_pkg::sqrt_bus_t         sq_out;
    logic [kdz_pkg::PROD_W-1:0] sc_prod;
    kdz_pkg::div_bus_t          sc_bus_next;
    kdz_pkg::div_bus_t          sc_bus_reg;
    logic                       sc_vld_reg;

    always_comb
    begin
        sq_out  = sq_bus[kdz_pkg::ROOT_W];
        sc_prod = sq_out.side.ad * sq_out.side.bg;

        sc_bus_next.vld     = 1'b1;
        sc_bus_next.rem     = '0;
        sc_bus_next.work    = {sc_prod, {(kdz_pkg::NUM_W-kdz_pkg::PROD_W){1'b0}}};
        sc_bus_next.dvs     = kdz_pkg::DIV_D_W'({sq_out.root, 6'd0});
        sc_bus_next.side    = sq_out.side;
        sc_bus_next.side.ok = sq_out.side.ok && (sq_out.root != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_vld_reg <= 1'b0;
        end
        else
        begin
            sc_vld_reg <= sq_out.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        sc_bus_reg <= sc_bus_next;
    end

    // Z divider chain.
    kdz_pkg::div_bus_t mag_bus [kdz_pkg::MAG_STEPS+1];

    always_comb
    begin
        mag_bus[0]     = sc_bus_reg;
        mag_bus[0].vld = sc_vld_reg;
    end

    for (genvar gk = 0; gk < kdz_pkg::MAG_STEPS; gk++)
    begin : g_mag_div
        kdz_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_bus  (mag_bus[gk]),
            .out_bus (mag_bus[gk+1])
        );
    end

    // Output stage: sign, saturation and the result register.
    kdz_pkg::div_bus_t          fin;
    logic [kdz_pkg::PROD_W-1:0] fin_mag;
    logic [31:0]                fin_z;
    logic                       fin_sat;
    logic                       done_reg;
    logic [1:0]                 deg_reg;
    logic [31:0]                z_reg;
    logic                       zv_reg;
    logic                       zs_reg;

    always_comb
    begin
        fin     = mag_bus[kdz_pkg::MAG_STEPS];
        fin_mag = fin.work[kdz_pkg::PROD_W-1:0];
        fin_z   = '0;
        fin_sat = 1'b0;
        if (fin.side.ok)
        begin
            if (fin.side.neg)
            begin
                if (fin_mag > kdz_pkg::PROD_W'(64'h8000_0000))
                begin
                    fin_z   = 32'h8000_0000;
                    fin_sat = 1'b1;
                end
                else
                begin
                    fin_z = 32'd0 - fin_mag[31:0];
                end
            end
            else
            begin
                if (fin_mag > kdz_pkg::PROD_W'(64'h7FFF_FFFF))
                begin
                    fin_z   = 32'h7FFF_FFFF;
                    fin_sat = 1'b1;
                end
                else
                begin
                    fin_z = fin_mag[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        deg_reg <= fin.side.deg;
        z_reg   <= fin_z;
        zv_reg  <= fin.side.ok;
        zs_reg  <= fin_sat;
    end

    assign done        = done_reg;
    assign degree_code = deg_reg;
    assign z_score     = z_reg;
    assign z_valid     = zv_reg;
    assign z_saturated = zs_reg;

endmodule
`default_nettype wire
